FILE: sv/adlp_pkg.sv
// ----------------------------------------------------------------------------
// adlp_pkg
// Shared constants and types for the ASCII decimal line parser.
// ----------------------------------------------------------------------------
package adlp_pkg;

  // longest line is LINE_MAX-1 held bytes
  localparam int LINE_MAX = 16;
  localparam int CNT_W    = $clog2(LINE_MAX);
  localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(LINE_MAX - 1);

  localparam int POS_W = 16;
  localparam int LEN_W = 4;

  // item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // characters of interest
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    ready_res;
    logic [LEN_W-1:0]        line_length;
  } result_t;

endpackage

FILE: sv/ascii_decimal_line_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_decimal_line_parser_unit
// Parses received bytes into signed 16-bit positions, one line at a time.
// ----------------------------------------------------------------------------
// Takes one item per clock while item_stall is low and returns exactly one
// registered result beat per accepted item. A byte item advances the running
// parse (whitespace skip, optional sign, decimal digits modulo 2^16) in a single
// pass of logic; LF or CR ends a non-empty line, latches the position and
// sets ready. A poll item reports ready as it was and clears it. The result
// side has an output register plus one skid entry, so input keeps flowing
// for one beat after the result side stalls; item_stall rises only when both
// entries are full.
module ascii_decimal_line_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              op,
  input  logic [7:0]                        rx_byte,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [adlp_pkg::POS_W-1:0] position,
  output logic                              ready_res,
  output logic [adlp_pkg::LEN_W-1:0]        line_length
);

  logic [adlp_pkg::CNT_W-1:0] held_count, held_count_next;
  adlp_pkg::phase_t           phase, phase_next;
  logic                       negative, negative_next;
  logic [adlp_pkg::POS_W-1:0] accumulator, accumulator_next;
  logic [adlp_pkg::POS_W-1:0] latched_value, latched_value_next;
  logic                       new_flag, new_flag_next;

  adlp_pkg::result_t result_new, out_reg, skid_reg;
  logic              skid_valid;

  logic       accept, take_out;
  logic       is_eol, is_blank, is_digit;
  logic [7:0] digit_diff;
  logic [adlp_pkg::POS_W-1:0] digit_val, acc_times_ten;
  logic [adlp_pkg::CNT_W+adlp_pkg::LEN_W-1:0] len_ext;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take_out   = result_valid && !result_stall;

  assign is_eol   = (rx_byte == adlp_pkg::CHAR_LF) || (rx_byte == adlp_pkg::CHAR_CR);
  assign is_blank = (rx_byte == adlp_pkg::CHAR_SPACE) || (rx_byte == adlp_pkg::CHAR_TAB) ||
                    (rx_byte == adlp_pkg::CHAR_VT) || (rx_byte == adlp_pkg::CHAR_FF);
  assign is_digit = (rx_byte >= adlp_pkg::CHAR_0) && (rx_byte <= adlp_pkg::CHAR_9);

  assign digit_diff    = rx_byte - adlp_pkg::CHAR_0;
  assign digit_val     = {12'h000, digit_diff[3:0]};
  // acc * 10 as two shifts and an add, wrapping at 16 bits
  assign acc_times_ten = {accumulator[12:0], 3'b000} + {accumulator[14:0], 1'b0};

  always_comb begin
    held_count_next    = held_count;
    phase_next         = phase;
    negative_next      = negative;
    accumulator_next   = accumulator;
    latched_value_next = latched_value;
    new_flag_next      = new_flag;
    result_new.ready_res = new_flag;

    if (op == adlp_pkg::OP_POLL) begin
      result_new.ready_res = new_flag;
      new_flag_next        = 1'b0;
    end else begin
      if (is_eol) begin
        if (held_count != '0) begin
          latched_value_next = negative ? (16'h0000 - accumulator) : accumulator;
          new_flag_next      = 1'b1;
          held_count_next    = '0;
          phase_next         = adlp_pkg::PH_SPACE;
          negative_next      = 1'b0;
          accumulator_next   = '0;
        end
      end else if (held_count < adlp_pkg::HELD_MAX) begin
        held_count_next = held_count + adlp_pkg::CNT_W'(1);
        case (phase)
          adlp_pkg::PH_SPACE: begin
            if (!is_blank) begin
              if (rx_byte == adlp_pkg::CHAR_PLUS) begin
                phase_next = adlp_pkg::PH_DIGITS;
              end else if (rx_byte == adlp_pkg::CHAR_MINUS) begin
                negative_next = 1'b1;
                phase_next    = adlp_pkg::PH_DIGITS;
              end else if (is_digit) begin
                accumulator_next = digit_val;
                phase_next       = adlp_pkg::PH_DIGITS;
              end else begin
                phase_next = adlp_pkg::PH_DONE;
              end
            end
          end
          adlp_pkg::PH_DIGITS: begin
            if (is_digit) begin
              accumulator_next = acc_times_ten + digit_val;
            end else begin
              phase_next = adlp_pkg::PH_DONE;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end else begin
        // overlong line: drop the byte and the held line
        held_count_next  = '0;
        phase_next       = adlp_pkg::PH_SPACE;
        negative_next    = 1'b0;
        accumulator_next = '0;
      end
      result_new.ready_res = new_flag_next;
    end

    len_ext                = {{adlp_pkg::LEN_W{1'b0}}, held_count_next};
    result_new.position    = latched_value_next;
    result_new.line_length = len_ext[adlp_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      phase         <= adlp_pkg::PH_SPACE;
      negative      <= 1'b0;
      accumulator   <= '0;
      latched_value <= '0;
      new_flag      <= 1'b0;
    end else if (accept) begin
      held_count    <= held_count_next;
      phase         <= phase_next;
      negative      <= negative_next;
      accumulator   <= accumulator_next;
      latched_value <= latched_value_next;
      new_flag      <= new_flag_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || take_out) begin
      if (skid_valid) begin
        out_reg      <= skid_reg;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else if (accept) begin
        out_reg      <= result_new;
        result_valid <= 1'b1;
      end else begin
        result_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_reg   <= result_new;
      skid_valid <= 1'b1;
    end
  end

  assign position    = out_reg.position;
  assign ready_res   = out_reg.ready_res;
  assign line_length = out_reg.line_length;

endmodule

FILE: sv/adlp_checker.sv
// ----------------------------------------------------------------------------
// adlp_assertions
// Port-level checks on the line parser's handshake and buffering.
// ----------------------------------------------------------------------------
module adlp_assertions (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] position,
  input logic        ready_res,
  input logic [3:0]  line_length
);

  // both buffer entries empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("buffer not empty after reset");

  // input stalls only when the output register is full too
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item_stall with no result pending");

  // skid fills only on a beat taken while the result side stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(item_stall) |-> $past(result_valid && result_stall && item_valid))
    else $error("item_stall rose without a stalled result");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(position) &&
      $stable(ready_res) && $stable(line_length))
    else $error("stalled result beat changed");

endmodule

bind ascii_decimal_line_parser_unit adlp_assertions u_adlp_assertions (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .position     (position),
  .ready_res    (ready_res),
  .line_length  (line_length)
);

FILE: tb/adlp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adlp_checker
// Watches both channels of the line parser, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every accepted item is run through a local copy of the parse state and the
// expected result is queued; every accepted result beat is checked field by
// field against the oldest queued entry.
module adlp_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic                              op,
  input  logic [7:0]                        rx_byte,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic signed [adlp_pkg::POS_W-1:0] position,
  input  logic                              ready_res,
  input  logic [adlp_pkg::LEN_W-1:0]        line_length,
  output int                                mismatches,
  output int                                outstanding
);

  int                         held;
  adlp_pkg::phase_t           phase;
  logic                       neg;
  logic [adlp_pkg::POS_W-1:0] acc;
  logic [adlp_pkg::POS_W-1:0] latched;
  logic                       flag;
  adlp_pkg::result_t          pos_q[$];
  adlp_pkg::result_t          want;

  function automatic bit is_blank(logic [7:0] c);
    return c == adlp_pkg::CHAR_SPACE || c == adlp_pkg::CHAR_TAB ||
           c == adlp_pkg::CHAR_VT || c == adlp_pkg::CHAR_FF;
  endfunction

  function automatic void clear_line();
    held  = 0;
    phase = adlp_pkg::PH_SPACE;
    neg   = 1'b0;
    acc   = '0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic dig;
    dig = (c >= adlp_pkg::CHAR_0) && (c <= adlp_pkg::CHAR_9);
    case (phase)
      adlp_pkg::PH_SPACE: begin
        if (!is_blank(c)) begin
          if (c == adlp_pkg::CHAR_PLUS) begin
            phase = adlp_pkg::PH_DIGITS;
          end else if (c == adlp_pkg::CHAR_MINUS) begin
            neg   = 1'b1;
            phase = adlp_pkg::PH_DIGITS;
          end else if (dig) begin
            acc   = adlp_pkg::POS_W'(c - adlp_pkg::CHAR_0);
            phase = adlp_pkg::PH_DIGITS;
          end else begin
            phase = adlp_pkg::PH_DONE;
          end
        end
      end
      adlp_pkg::PH_DIGITS: begin
        // wraps modulo 2^16
        if (dig) acc = acc * adlp_pkg::POS_W'(10) + adlp_pkg::POS_W'(c - adlp_pkg::CHAR_0);
        else phase = adlp_pkg::PH_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic adlp_pkg::result_t predict_result(logic o, logic [7:0] c);
    adlp_pkg::result_t r;
    if (o == adlp_pkg::OP_POLL) begin
      r.ready_res = flag;
      flag = 1'b0;
    end else begin
      if (c == adlp_pkg::CHAR_LF || c == adlp_pkg::CHAR_CR) begin
        // empty line does nothing
        if (held > 0) begin
          latched = neg ? (~acc + 1'b1) : acc;
          flag    = 1'b1;
          clear_line();
        end
      end else if (held < adlp_pkg::LINE_MAX - 1) begin
        held++;
        take_char(c);
      end else begin
        // overlong line: drop the byte and the held line
        clear_line();
      end
      r.ready_res = flag;
    end
    r.position    = latched;
    r.line_length = adlp_pkg::LEN_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      latched = '0;
      flag    = 1'b0;
      pos_q.delete();
    end else begin
      // compare first: a result in the same cycle belongs to an older item
      if (result_valid && !result_stall) begin
        if (pos_q.size() == 0) begin
          $error("result beat with no item pending");
          mismatches++;
        end else begin
          want = pos_q.pop_front();
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", $signed(want.position), position);
            mismatches++;
          end
          if (ready_res !== want.ready_res) begin
            $error("ready_res: expected %0b, got %0b", want.ready_res, ready_res);
            mismatches++;
          end
          if (line_length !== want.line_length) begin
            $error("line_length: expected %0d, got %0d", want.line_length, line_length);
            mismatches++;
          end
        end
      end
      if (item_valid && !item_stall) pos_q.push_back(predict_result(op, rx_byte));
    end
    outstanding = pos_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ASCII decimal line parser.
// ----------------------------------------------------------------------------
// A short directed run of lines and polls, then random lines, polls, noise
// and overlong lines under three flow-control profiles. Checking is done by
// adlp_checker.
module testbench;

  localparam int ITEM_TARGET = 1450;
  localparam int CYCLE_LIMIT = 200000;

  logic                              clk;
  logic                              rst;
  logic                              item_valid;
  logic                              item_stall;
  logic                              op;
  logic [7:0]                        rx_byte;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  logic signed [adlp_pkg::POS_W-1:0] position;
  logic                              ready_res;
  logic [adlp_pkg::LEN_W-1:0]        line_length;

  int mismatches;
  int outstanding;
  int sent;
  int cycles;
  int send_idle;
  int recv_idle;
  int base;

  ascii_decimal_line_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .ready_res    (ready_res),
    .line_length  (line_length)
  );

  adlp_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .ready_res    (ready_res),
    .line_length  (line_length),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(input logic o, input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    op         <= o;
    rx_byte    <= c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(adlp_pkg::OP_BYTE, s[i]);
  endtask

  task automatic poll();
    send(adlp_pkg::OP_POLL, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == adlp_pkg::CHAR_LF || c == adlp_pkg::CHAR_CR) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(1) ? adlp_pkg::CHAR_LF : adlp_pkg::CHAR_CR;
  endfunction

  function automatic logic [7:0] rand_digit();
    return adlp_pkg::CHAR_0 + 8'($urandom_range(9));
  endfunction

  task automatic random_line();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 55) begin
      repeat ($urandom_range(2)) begin
        case ($urandom_range(3))
          0: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_SPACE);
          1: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_TAB);
          2: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_VT);
          default: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_FF);
        endcase
      end
      case ($urandom_range(2))
        1: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_PLUS);
        2: send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_MINUS);
        default: ;
      endcase
      n = $urandom_range(1, 7);
      repeat (n) begin
        send(adlp_pkg::OP_BYTE, rand_digit());
        if ($urandom_range(19) == 0) poll();
      end
      if ($urandom_range(4) == 0) send(adlp_pkg::OP_BYTE, junk_byte());
      send(adlp_pkg::OP_BYTE, line_end());
    end else if (kind < 72) begin
      poll();
    end else if (kind < 80) begin
      // runs up to or past the line limit, mostly digits
      n = $urandom_range(adlp_pkg::LINE_MAX - 1, adlp_pkg::LINE_MAX + 4);
      repeat (n) begin
        if ($urandom_range(3) == 0) send(adlp_pkg::OP_BYTE, junk_byte());
        else send(adlp_pkg::OP_BYTE, rand_digit());
      end
      send(adlp_pkg::OP_BYTE, line_end());
    end else if (kind < 90) begin
      send(adlp_pkg::OP_BYTE, 8'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: send(adlp_pkg::OP_BYTE,
                $urandom_range(1) ? adlp_pkg::CHAR_PLUS : adlp_pkg::CHAR_MINUS);
        1: begin
          send(adlp_pkg::OP_BYTE, junk_byte());
          repeat ($urandom_range(3)) send(adlp_pkg::OP_BYTE, rand_digit());
        end
        default: ;
      endcase
      send(adlp_pkg::OP_BYTE, line_end());
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    op         = adlp_pkg::OP_BYTE;
    rx_byte    = 8'h00;
    send_idle  = 31;
    recv_idle  = 53;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty line, then the most negative value and a double poll
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_CR);
    send_text("-32768\n");
    poll();
    poll();
    // tab, vertical tab and form feed before an explicit plus
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_TAB);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_VT);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_FF);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_PLUS);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_9);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_LF);
    // lone sign latches zero
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_MINUS);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_CR);
    // parse stops at a letter, NUL is still counted
    send_text("9Z");
    send(adlp_pkg::OP_BYTE, 8'h00);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_LF);
    // all-ones byte, no digits
    send(adlp_pkg::OP_BYTE, 8'hFF);
    send(adlp_pkg::OP_BYTE, adlp_pkg::CHAR_LF);

    base = sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 31;
          recv_idle = 53;
        end
        1: begin
          send_idle = 53;
          recv_idle = 31;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      while (sent < base + (ph + 1) * ITEM_TARGET / 3) random_line();
      // hold off until every result is back
      drain();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
